[rtl/core/pgn_pkg.sv]
// Shared types and constants of the 3D gradient noise block.
`default_nettype none
package pgn_pkg;

  localparam int TABLE_SIZE_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;

  // cycles from an accepted evaluate beat to its result strobe
  localparam int PIPE_LAT = 9;

  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [17:0] THREE_Q16 = 18'd196608;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [1:0] TSEL_PERM_X = 2'd0;
  localparam logic [1:0] TSEL_PERM_Y = 2'd1;
  localparam logic [1:0] TSEL_PERM_Z = 2'd2;
  localparam logic [1:0] TSEL_GRAD   = 2'd3;

  localparam int NUM_CORNERS = 8;

  // packed gradient: x in [47:32], y in [31:16], z in [15:0]
  typedef logic [47:0] grad_t;

  // table write request: one-hot enable per table (perm x, y, z, gradient)
  typedef struct packed {
    logic [3:0] we;
    logic [7:0] index;
    logic [7:0] perm;
    grad_t      grad;
  } ld_t;

endpackage
`default_nettype wire

[rtl/core/pgn_ram.sv]
// Generic RAM: one write port, two registered read ports, read-old on collision.
`default_nettype none
module pgn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pgn_pkg::TABLE_SIZE_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule
`default_nettype wire

[rtl/core/pgn_hash.sv]
// Permutation tables and corner hashing (stage 1).
`default_nettype none
module pgn_hash #(
  parameter int TABLE_SIZE = pgn_pkg::TABLE_SIZE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          eval_i,
  input  wire pgn_pkg::ld_t                  ld_i,
  input  wire logic [$clog2(TABLE_SIZE)-1:0] cell_i [3],
  input  wire logic [15:0]                   frac_i [3],
  output logic                               valid_o,
  output logic      [$clog2(TABLE_SIZE)-1:0] hash_o [pgn_pkg::NUM_CORNERS],
  output logic      [15:0]                   frac_o [3]
);

  localparam int AW = $clog2(TABLE_SIZE);

  logic [AW+7:0]   widx_ext;
  logic [AW-1:0]   waddr;
  logic [AW-1:0]   cell_hi [3];
  logic [7:0]      p_lo [3];
  logic [7:0]      p_hi [3];
  logic            valid_r;
  logic [15:0]     frac_r [3];

  assign widx_ext = {{AW{1'b0}}, ld_i.index};
  assign waddr    = widx_ext[AW-1:0];

  for (genvar g = 0; g < 3; g++) begin : g_perm
    assign cell_hi[g] = cell_i[g] + AW'(1);
    pgn_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_perm (
      .clk     (clk),
      .we      (ld_i.we[g]),
      .waddr   (waddr),
      .wdata   (ld_i.perm),
      .raddr_a (cell_i[g]),
      .raddr_b (cell_hi[g]),
      .rdata_a (p_lo[g]),
      .rdata_b (p_hi[g])
    );
  end

  // corner bits: x = c[2], y = c[1], z = c[0]
  for (genvar c = 0; c < pgn_pkg::NUM_CORNERS; c++) begin : g_corner
    logic [7:0]    h8;
    logic [AW+7:0] h_ext;
    assign h8        = (c[2] ? p_hi[0] : p_lo[0]) ^ (c[1] ? p_hi[1] : p_lo[1])
                     ^ (c[0] ? p_hi[2] : p_lo[2]);
    assign h_ext     = {{AW{1'b0}}, h8};
    assign hash_o[c] = h_ext[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= eval_i;
    end
  end

  always_ff @(posedge clk) begin
    frac_r <= frac_i;
  end

  assign valid_o = valid_r;
  assign frac_o  = frac_r;

endmodule
`default_nettype wire

[rtl/core/pgn_fade.sv]
// Smoothstep and trilinear corner weights, four register stages.
`default_nettype none
module pgn_fade (
  input  wire logic        clk,
  input  wire logic [15:0] frac_i [3],
  output logic      [16:0] weight_o [pgn_pkg::NUM_CORNERS]
);

  logic [15:0] f_r   [3];
  logic [15:0] f2_r  [3];
  logic [16:0] s_r   [3];
  logic [16:0] wxy_r [4];
  logic [16:0] wz_r  [2];
  logic [16:0] w_r   [pgn_pkg::NUM_CORNERS];

  logic [31:0] sq    [3];
  logic [17:0] slope [3];
  logic [33:0] sprod [3];
  logic [16:0] wlo   [3];
  logic [33:0] pxy   [4];
  logic [33:0] pxyz  [pgn_pkg::NUM_CORNERS];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sq[a]    = frac_i[a] * frac_i[a];
      slope[a] = pgn_pkg::THREE_Q16 - {1'b0, f_r[a], 1'b0};
      sprod[a] = f2_r[a] * slope[a];
      wlo[a]   = pgn_pkg::ONE_Q16 - s_r[a];
    end
    // index {bx, by}
    for (int k = 0; k < 4; k++) begin
      pxy[k] = (k[1] ? s_r[0] : wlo[0]) * (k[0] ? s_r[1] : wlo[1]);
    end
    for (int c = 0; c < pgn_pkg::NUM_CORNERS; c++) begin
      pxyz[c] = wxy_r[c[2:1]] * wz_r[c[0]];
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      f_r[a]  <= frac_i[a];
      f2_r[a] <= sq[a][31:16];
      s_r[a]  <= sprod[a][32:16];
    end
    for (int k = 0; k < 4; k++) begin
      wxy_r[k] <= pxy[k][32:16];
    end
    wz_r[0] <= wlo[2];
    wz_r[1] <= s_r[2];
    for (int c = 0; c < pgn_pkg::NUM_CORNERS; c++) begin
      w_r[c] <= pxyz[c][32:16];
    end
  end

  assign weight_o = w_r;

endmodule
`default_nettype wire

[rtl/core/pgn_accum.sv]
// Dot products, weighting, adder tree and saturation (stages 2 to 9).
`default_nettype none
module pgn_accum (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  valid_i,
  input  wire logic [15:0]           frac_i [3],
  input  wire pgn_pkg::grad_t        grad_i [pgn_pkg::NUM_CORNERS],
  input  wire logic [16:0]           weight_i [pgn_pkg::NUM_CORNERS],
  output logic                       out_valid,
  output logic signed [15:0]         out_noise_value,
  output logic                       out_clipped
);

  localparam logic signed [23:0] SAT_HI = 24'sd32767;
  localparam logic signed [23:0] SAT_LO = -24'sd32768;

  // valid_r[k] is the valid of stage k+2
  logic [7:0]         valid_r;
  logic [15:0]        f_r [3];
  logic signed [32:0] prod_r [pgn_pkg::NUM_CORNERS][3];
  logic signed [34:0] dot_r  [pgn_pkg::NUM_CORNERS];
  logic signed [52:0] term_r [pgn_pkg::NUM_CORNERS];
  logic signed [53:0] pair_r [4];
  logic signed [54:0] quad_r [2];
  logic signed [55:0] sum_r;
  logic signed [15:0] noise_r;
  logic               clip_r;

  logic signed [16:0] ofs   [pgn_pkg::NUM_CORNERS][3];
  logic signed [15:0] gcomp [pgn_pkg::NUM_CORNERS][3];
  logic signed [23:0] res;

  always_comb begin
    for (int c = 0; c < pgn_pkg::NUM_CORNERS; c++) begin
      gcomp[c][0] = $signed(grad_i[c][47:32]);
      gcomp[c][1] = $signed(grad_i[c][31:16]);
      gcomp[c][2] = $signed(grad_i[c][15:0]);
      // lower corner: f, upper corner: f - 1
      ofs[c][0] = $signed({1'b0, f_r[0]}) - (c[2] ? $signed(pgn_pkg::ONE_Q16) : 17'sd0);
      ofs[c][1] = $signed({1'b0, f_r[1]}) - (c[1] ? $signed(pgn_pkg::ONE_Q16) : 17'sd0);
      ofs[c][2] = $signed({1'b0, f_r[2]}) - (c[0] ? $signed(pgn_pkg::ONE_Q16) : 17'sd0);
    end
    res = sum_r[55:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[6:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    f_r <= frac_i;
    for (int c = 0; c < pgn_pkg::NUM_CORNERS; c++) begin
      for (int a = 0; a < 3; a++) begin
        prod_r[c][a] <= gcomp[c][a] * ofs[c][a];
      end
      dot_r[c]  <= 35'(prod_r[c][0]) + 35'(prod_r[c][1]) + 35'(prod_r[c][2]);
      term_r[c] <= dot_r[c] * $signed({1'b0, weight_i[c]});
    end
    for (int k = 0; k < 4; k++) begin
      pair_r[k] <= 54'(term_r[2*k]) + 54'(term_r[2*k+1]);
    end
    for (int k = 0; k < 2; k++) begin
      quad_r[k] <= 55'(pair_r[2*k]) + 55'(pair_r[2*k+1]);
    end
    sum_r <= 56'(quad_r[0]) + 56'(quad_r[1]);
    if (res > SAT_HI) begin
      noise_r <= SAT_HI[15:0];
      clip_r  <= 1'b1;
    end else if (res < SAT_LO) begin
      noise_r <= SAT_LO[15:0];
      clip_r  <= 1'b1;
    end else begin
      noise_r <= res[15:0];
      clip_r  <= 1'b0;
    end
  end

  assign out_valid       = valid_r[7];
  assign out_noise_value = noise_r;
  assign out_clipped     = clip_r;

endmodule
`default_nettype wire

[rtl/core/perlin_gradient_noise_3d.sv]
// Top level of the 3D gradient noise evaluator.
//
// One beat per cycle, every cycle: busy never rises, and a beat is taken at
// any edge with start high. A load beat (in_op = 0) writes one entry of the
// x, y or z permutation table or of the gradient table at that edge and
// gives no result. An evaluate beat (in_op = 1) gives exactly one result,
// shown on out_noise_value and out_clipped with out_valid high for a single
// cycle once the beat leaves stage 9; results come in beat order. The
// receiver cannot hold results off. Tables have no reset value: load every
// entry that an evaluation may touch before evaluating. A load taken after
// an evaluate beat never affects that evaluation.
//
// Pipeline: stage 1 reads the permutation tables at cell and cell+1 per
// axis; stage 2 reads the gradients of the eight hashed corners from four
// dual-read copies of the gradient table; stages 3-4 form the dot products
// while a parallel path forms the smoothstep weights; stage 5 weights each
// corner; stages 6-8 are an adder tree; stage 9 floors to Q2.14 and clips.
// TABLE_SIZE must be a power of two.
`default_nettype none
module perlin_gradient_noise_3d #(
  parameter int TABLE_SIZE = pgn_pkg::TABLE_SIZE_DEF,
  parameter int FRAC_BITS  = pgn_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_op,
  input  wire logic        [1:0]  in_table_select,
  input  wire logic        [7:0]  in_entry_index,
  input  wire logic        [7:0]  in_perm_entry,
  input  wire logic signed [15:0] in_grad_x,
  input  wire logic signed [15:0] in_grad_y,
  input  wire logic signed [15:0] in_grad_z,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic signed [31:0] in_point_z,
  output logic                    out_valid,
  output logic signed [15:0]      out_noise_value,
  output logic                    out_clipped
);

  localparam int AW = $clog2(TABLE_SIZE);

  logic                  accept;
  logic                  eval;
  pgn_pkg::ld_t          ld;
  logic signed [31:0]    pt      [3];
  logic        [AW-1:0]  lat     [3];
  logic        [15:0]    frac0   [3];
  logic                  valid1;
  logic        [AW-1:0]  hash1   [pgn_pkg::NUM_CORNERS];
  logic        [15:0]    frac1   [3];
  pgn_pkg::grad_t        grad2   [pgn_pkg::NUM_CORNERS];
  logic        [16:0]    weight4 [pgn_pkg::NUM_CORNERS];
  logic        [AW+7:0]  widx_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign eval   = accept && (in_op == pgn_pkg::OP_EVAL);

  // table write request
  always_comb begin
    ld.we    = '0;
    ld.index = in_entry_index;
    ld.perm  = in_perm_entry;
    ld.grad  = {in_grad_x, in_grad_y, in_grad_z};
    if (accept && (in_op == pgn_pkg::OP_LOAD)) begin
      case (in_table_select)
        pgn_pkg::TSEL_PERM_X: ld.we[0] = 1'b1;
        pgn_pkg::TSEL_PERM_Y: ld.we[1] = 1'b1;
        pgn_pkg::TSEL_PERM_Z: ld.we[2] = 1'b1;
        pgn_pkg::TSEL_GRAD:   ld.we[3] = 1'b1;
        default:              ld.we    = '0;
      endcase
    end
  end

  assign pt[0] = in_point_x;
  assign pt[1] = in_point_y;
  assign pt[2] = in_point_z;

  // floor cell and Q0.16 fraction per axis
  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [31:0]          cl;
    logic        [FRAC_BITS+15:0] fext;
    assign cl       = pt[a] >>> FRAC_BITS;
    assign lat[a]   = cl[AW-1:0];
    assign fext     = {pt[a][FRAC_BITS-1:0], 16'b0};
    assign frac0[a] = fext[FRAC_BITS+15:FRAC_BITS];
  end

  pgn_hash #(.TABLE_SIZE(TABLE_SIZE)) u_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .eval_i  (eval),
    .ld_i    (ld),
    .cell_i  (lat),
    .frac_i  (frac0),
    .valid_o (valid1),
    .hash_o  (hash1),
    .frac_o  (frac1)
  );

  // gradient table: four copies, two corners each
  assign widx_ext = {{AW{1'b0}}, ld.index};

  for (genvar k = 0; k < pgn_pkg::NUM_CORNERS / 2; k++) begin : g_grad
    pgn_ram #(.WIDTH($bits(pgn_pkg::grad_t)), .DEPTH(TABLE_SIZE)) u_grad (
      .clk     (clk),
      .we      (ld.we[3]),
      .waddr   (widx_ext[AW-1:0]),
      .wdata   (ld.grad),
      .raddr_a (hash1[2*k]),
      .raddr_b (hash1[2*k+1]),
      .rdata_a (grad2[2*k]),
      .rdata_b (grad2[2*k+1])
    );
  end

  pgn_fade u_fade (
    .clk      (clk),
    .frac_i   (frac0),
    .weight_o (weight4)
  );

  pgn_accum u_accum (
    .clk             (clk),
    .rst_n           (rst_n),
    .valid_i         (valid1),
    .frac_i          (frac1),
    .grad_i          (grad2),
    .weight_i        (weight4),
    .out_valid       (out_valid),
    .out_noise_value (out_noise_value),
    .out_clipped     (out_clipped)
  );

endmodule
`default_nettype wire

[rtl/core/pgn_checker.sv]
// Port-level checker for the noise block, bound to the top level.
`default_nettype none
module pgn_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               in_op,
  input wire logic               out_valid,
  input wire logic signed [15:0] out_noise_value,
  input wire logic               out_clipped
);

  logic [3:0] up_cnt_r;
  logic [3:0] up_cnt_nxt;
  logic       acc_eval;
  logic       acc_load;

  assign acc_eval   = start && !busy && (in_op == pgn_pkg::OP_EVAL);
  assign acc_load   = start && !busy && (in_op == pgn_pkg::OP_LOAD);
  assign up_cnt_nxt = (up_cnt_r == 4'(pgn_pkg::PIPE_LAT)) ? up_cnt_r : up_cnt_r + 4'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_cnt_r <= '0;
    end else begin
      up_cnt_r <= up_cnt_nxt;
    end
  end

  a_eval_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (up_cnt_r == 4'(pgn_pkg::PIPE_LAT)) && $past(acc_eval, pgn_pkg::PIPE_LAT)
      |-> out_valid)
    else $error("evaluate beat without result");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(acc_load, pgn_pkg::PIPE_LAT) |-> !out_valid)
    else $error("result after load beat");

  a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |->
      (out_noise_value == 16'sh7fff) || (out_noise_value == -16'sh8000))
    else $error("clipped result not at a rail");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

endmodule

bind perlin_gradient_noise_3d pgn_checker u_pgn_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_op           (in_op),
  .out_valid       (out_valid),
  .out_noise_value (out_noise_value),
  .out_clipped     (out_clipped)
);
`default_nettype wire

[dv/perlin_gradient_noise_3d_test.sv]
// Self-checking testbench of the 3D gradient noise evaluator: table loads and evaluations.
`default_nettype none
module perlin_gradient_noise_3d_test;

  // expected noise beat
  typedef struct {
    logic signed [15:0] noise;
    logic               clip;
  } noise_exp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_op = pgn_pkg::OP_LOAD;
  logic [1:0] in_table_select = pgn_pkg::TSEL_PERM_X;
  logic [7:0] in_entry_index = '0;
  logic [7:0] in_perm_entry = '0;
  logic signed [15:0] in_grad_x = '0;
  logic signed [15:0] in_grad_y = '0;
  logic signed [15:0] in_grad_z = '0;
  logic signed [31:0] in_point_x = '0;
  logic signed [31:0] in_point_y = '0;
  logic signed [31:0] in_point_z = '0;
  logic out_valid;
  logic signed [15:0] out_noise_value;
  logic out_clipped;

  // shadow copies of the tables
  logic [7:0] perm_x_sh [256];
  logic [7:0] perm_y_sh [256];
  logic [7:0] perm_z_sh [256];
  logic signed [15:0] grad_sh [256][3];

  noise_exp_t pending_noise[$];
  int errors = 0;
  int loads_sent = 0;
  int evals_sent = 0;
  int results_seen = 0;
  int clips_seen = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  localparam int WATCHDOG_LIMIT = 5000;

  perlin_gradient_noise_3d u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_table_select(in_table_select),
    .in_entry_index(in_entry_index), .in_perm_entry(in_perm_entry),
    .in_grad_x(in_grad_x), .in_grad_y(in_grad_y), .in_grad_z(in_grad_z),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .out_valid(out_valid), .out_noise_value(out_noise_value),
    .out_clipped(out_clipped)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hermite smoothstep in Q16
  function automatic longint smooth_q16(longint f);
    longint f2;
    f2 = (f * f) >>> 16;
    return (f2 * (3 * 65536 - 2 * f)) >>> 16;
  endfunction

  // Noise at a point, from the shadow tables
  function automatic noise_exp_t noise_at(logic signed [31:0] px, logic signed [31:0] py,
                                          logic signed [31:0] pz);
    logic signed [31:0] pt [3];
    logic [7:0] lat [3];
    longint fr [3];
    longint sm [3];
    longint acc, w, wx, wy, wz, dot, res;
    logic [7:0] h;
    int bx, by, bz;
    noise_exp_t r;
    pt[0] = px; pt[1] = py; pt[2] = pz;
    for (int a = 0; a < 3; a++) begin
      lat[a] = 8'(pt[a] >>> 16);
      fr[a] = longint'(pt[a][15:0]);
      sm[a] = smooth_q16(fr[a]);
    end
    acc = 0;
    for (int c = 0; c < 8; c++) begin
      bx = (c >> 2) & 1; by = (c >> 1) & 1; bz = c & 1;
      h = perm_x_sh[8'(lat[0] + bx)] ^ perm_y_sh[8'(lat[1] + by)]
          ^ perm_z_sh[8'(lat[2] + bz)];
      wx = bx ? sm[0] : 65536 - sm[0];
      wy = by ? sm[1] : 65536 - sm[1];
      wz = bz ? sm[2] : 65536 - sm[2];
      w = (((wx * wy) >>> 16) * wz) >>> 16;
      dot = longint'(grad_sh[h][0]) * (fr[0] - bx * 65536)
          + longint'(grad_sh[h][1]) * (fr[1] - by * 65536)
          + longint'(grad_sh[h][2]) * (fr[2] - bz * 65536);
      acc += dot * w;
    end
    res = acc >>> 32;  // arithmetic shift floors
    r.clip = 1'b0;
    if (res > 32767) begin
      res = 32767; r.clip = 1'b1;
    end else if (res < -32768) begin
      res = -32768; r.clip = 1'b1;
    end
    r.noise = 16'(res);
    return r;
  endfunction

  // One beat, with bursty gaps before it
  task automatic send_beat(logic op, logic [1:0] tsel, logic [7:0] idx, logic [7:0] pv,
                           logic signed [15:0] gx, logic signed [15:0] gy,
                           logic signed [15:0] gz, logic signed [31:0] px,
                           logic signed [31:0] py, logic signed [31:0] pz);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_op <= op; in_table_select <= tsel; in_entry_index <= idx; in_perm_entry <= pv;
    in_grad_x <= gx; in_grad_y <= gy; in_grad_z <= gz;
    in_point_x <= px; in_point_y <= py; in_point_z <= pz;
    do @(posedge clk); while (busy);
    // beat accepted at this edge; update the shadow model
    if (op == pgn_pkg::OP_LOAD) begin
      loads_sent++;
      case (tsel)
        pgn_pkg::TSEL_PERM_X: perm_x_sh[idx] = pv;
        pgn_pkg::TSEL_PERM_Y: perm_y_sh[idx] = pv;
        pgn_pkg::TSEL_PERM_Z: perm_z_sh[idx] = pv;
        default: begin
          grad_sh[idx][0] = gx; grad_sh[idx][1] = gy; grad_sh[idx][2] = gz;
        end
      endcase
    end else begin
      evals_sent++;
      pending_noise.push_back(noise_at(px, py, pz));
    end
  endtask

  task automatic load_perm(logic [1:0] tsel, logic [7:0] idx, logic [7:0] pv);
    send_beat(pgn_pkg::OP_LOAD, tsel, idx, pv, '0, '0, '0, '0, '0, '0);
  endtask

  task automatic load_grad(logic [7:0] idx, logic signed [15:0] gx,
                           logic signed [15:0] gy, logic signed [15:0] gz);
    send_beat(pgn_pkg::OP_LOAD, pgn_pkg::TSEL_GRAD, idx, 8'($urandom), gx, gy, gz,
              $urandom, $urandom, $urandom);
  endtask

  task automatic eval_point(logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] pz);
    send_beat(pgn_pkg::OP_EVAL, 2'($urandom), 8'($urandom), 8'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom), px, py, pz);
  endtask

  // Random gradient: mostly unit range, sometimes any 16-bit value
  function automatic logic signed [15:0] rand_grad();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // Random point; the lattice low byte stays in 240..255 or 0..14 so that
  // both corners per axis hit loaded permutation entries
  function automatic logic signed [31:0] rand_coord();
    logic [7:0]  hb;
    logic [7:0]  lb;
    logic [15:0] fb;
    lb = 8'($urandom_range(0, 30) + 240);
    case ($urandom_range(0, 1))
      0: hb = 8'($urandom);
      default: hb = {8{lb[7]}};
    endcase
    case ($urandom_range(0, 7))
      0: fb = 16'h0000;
      1: fb = 16'hFFFF;
      default: fb = 16'($urandom);
    endcase
    return {hb, lb, fb};
  endfunction

  // Load permutation entries 240..255 and 0..15 and the whole gradient table
  task automatic test_fill_tables(bit ramp);
    logic [7:0] idx;
    for (int i = 0; i < 32; i++) begin
      idx = 8'(i + 240);
      load_perm(pgn_pkg::TSEL_PERM_X, idx, ramp ? idx : 8'($urandom));
      load_perm(pgn_pkg::TSEL_PERM_Y, idx, ramp ? 8'(255 - idx) : 8'($urandom));
      load_perm(pgn_pkg::TSEL_PERM_Z, idx, ramp ? 8'(idx * 3) : 8'($urandom));
    end
    for (int i = 0; i < 256; i++)
      load_grad(8'(i), rand_grad(), rand_grad(), rand_grad());
  endtask

  // Field extremes, integer and negative points, gradients aimed for clipping
  task automatic test_directed_points();
    eval_point(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
    eval_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    eval_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    eval_point(32'shFFFF_FFFF, 32'sh0000_8000, 32'sh0000_FFFF);
    eval_point(-32'sh0001_8000, 32'sh0003_0000, -32'sh0000_0001);
    eval_point(32'sh00FF_8000, 32'sh0100_4000, 32'shFF00_C000);
    // cell 0: hash of corner {bx,by,bz} is the corner number itself
    load_perm(pgn_pkg::TSEL_PERM_X, 8'd0, 8'd0);
    load_perm(pgn_pkg::TSEL_PERM_X, 8'd1, 8'd4);
    load_perm(pgn_pkg::TSEL_PERM_Y, 8'd0, 8'd0);
    load_perm(pgn_pkg::TSEL_PERM_Y, 8'd1, 8'd2);
    load_perm(pgn_pkg::TSEL_PERM_Z, 8'd0, 8'd0);
    load_perm(pgn_pkg::TSEL_PERM_Z, 8'd1, 8'd1);
    // full-scale gradients pointing at the cell center: positive rail at the center
    for (int h = 0; h < 8; h++)
      load_grad(8'(h), h[2] ? 16'sh8000 : 16'sh7FFF, h[1] ? 16'sh8000 : 16'sh7FFF,
                h[0] ? 16'sh8000 : 16'sh7FFF);
    eval_point(32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000);
    eval_point(32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0001);
    // pointing away from the center: negative rail at the center
    for (int h = 0; h < 8; h++)
      load_grad(8'(h), h[2] ? 16'sh7FFF : 16'sh8000, h[1] ? 16'sh7FFF : 16'sh8000,
                h[0] ? 16'sh7FFF : 16'sh8000);
    eval_point(32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000);
    eval_point(32'sh0000_FFFF, 32'sh0000_FFFF, 32'sh0000_FFFF);
  endtask

  // Mostly evaluations with random loads mixed in
  task automatic test_random_mix(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0) begin
        logic [1:0] tsel;
        tsel = 2'($urandom);
        if (tsel == pgn_pkg::TSEL_GRAD)
          load_grad(8'($urandom), rand_grad(), rand_grad(), rand_grad());
        else load_perm(tsel, 8'($urandom), 8'($urandom));
      end else
        eval_point(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  // Hold off until the pipeline drains completely
  task automatic test_drain_pause();
    start <= 1'b0;
    do @(posedge clk); while (pending_noise.size() != 0);
    burst_left = 0;
  endtask

  // Result checker: one beat per out_valid cycle
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      noise_exp_t e;
      if (pending_noise.size() == 0) begin
        $display("%0t: unexpected result noise=%0d clipped=%0b", $time,
                 out_noise_value, out_clipped);
        errors++;
      end else begin
        e = pending_noise.pop_front();
        results_seen++;
        if (e.clip) clips_seen++;
        if (out_noise_value !== e.noise) begin
          $display("%0t: noise_value expected %0d actual %0d", $time, e.noise,
                   out_noise_value);
          errors++;
        end
        if (out_clipped !== e.clip) begin
          $display("%0t: clipped expected %0b actual %0b", $time, e.clip, out_clipped);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat or result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int settle;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_tables(1'b1);
    test_directed_points();
    test_random_mix(320);
    test_drain_pause();
    test_random_mix(400);
    start <= 1'b0;
    settle = 0;
    while (pending_noise.size() != 0 && settle < 1000) begin
      @(posedge clk);
      settle++;
    end
    repeat (pgn_pkg::PIPE_LAT + 4) @(posedge clk);
    if (pending_noise.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_noise.size());
      errors++;
    end
    $display("Covered %0d table loads and %0d evaluations, %0d results checked (%0d clipped).",
             loads_sent, evals_sent, results_seen, clips_seen);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
